### sv/dup_pkg.sv
// ----------------------------------------------------------------------------
// dup_pkg
// Types, constants and character classifiers shared by the payload decoder.
// ----------------------------------------------------------------------------
package dup_pkg;

  localparam logic [7:0] PCT_CHAR     = 8'h25;
  localparam int         B64_BITS     = 6;
  localparam int         BYTE_BITS    = 8;
  localparam int         MAX_RESULTS  = 3;

  localparam logic [1:0] ESC_NONE  = 2'd0;
  localparam logic [1:0] ESC_PCT   = 2'd1;
  localparam logic [1:0] ESC_DIGIT = 2'd2;

  localparam logic MODE_PERCENT = 1'b0;
  localparam logic MODE_BASE64  = 1'b1;

  typedef struct packed {
    logic [11:0] bit_buffer;
    logic [3:0]  bit_count;
    logic [1:0]  escape_stage;
    logic [7:0]  held_char;
  } dup_state_t;

  typedef struct packed {
    logic [1:0]                      count;
    logic [MAX_RESULTS-1:0][7:0]     bytes;
  } dup_group_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } dup_hex_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } dup_b64_t;

  function automatic dup_hex_t hex_digit(input logic [7:0] c);
    dup_hex_t r;
    r.valid = 1'b1;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.value = 4'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.value = 4'(c - 8'h41 + 8'd10);
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

  function automatic dup_b64_t b64_value(input logic [7:0] c);
    dup_b64_t r;
    r.valid = 1'b1;
    r.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.value = 6'd62;
    end else if (c == 8'h2F) begin
      r.value = 6'd63;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

### sv/dup_decode.sv
// ----------------------------------------------------------------------------
// dup_decode
// Combinational step: one character against the current state gives the next
// state and a group of up to three decoded bytes.
// ----------------------------------------------------------------------------
module dup_decode (
  input  logic               mode,
  input  logic [7:0]         in_char,
  input  logic               in_last,
  input  dup_pkg::dup_state_t state,
  output dup_pkg::dup_state_t state_next,
  output dup_pkg::dup_group_t group
);
  import dup_pkg::*;

  dup_hex_t   hx_c;
  dup_hex_t   hx_held;
  dup_b64_t   b64;
  logic [4:0] sum;
  logic [3:0] cnt;
  logic [11:0] buf_new;
  logic       start_esc;

  always_comb begin
    hx_c      = hex_digit(in_char);
    hx_held   = hex_digit(state.held_char);
    b64       = b64_value(in_char);
    buf_new   = {state.bit_buffer[11-B64_BITS:0], b64.value};
    sum       = 5'(state.bit_count) + 5'(B64_BITS);
    cnt       = 4'(sum - 5'(BYTE_BITS));
    start_esc = (in_char == PCT_CHAR) && !in_last;

    state_next  = state;
    group.count = 2'd0;
    group.bytes = '0;

    if (mode == MODE_BASE64) begin
      if (b64.valid) begin
        state_next.bit_buffer = buf_new;
        if (sum >= 5'(BYTE_BITS)) begin
          state_next.bit_count = cnt;
          group.bytes[0]       = 8'(buf_new >> cnt);
          group.count          = 2'd1;
        end else begin
          state_next.bit_count = sum[3:0];
        end
      end
    end else begin
      state_next.escape_stage = ESC_NONE;
      case (state.escape_stage)
        ESC_PCT: begin
          if (hx_c.valid && !in_last) begin
            state_next.held_char    = in_char;
            state_next.escape_stage = ESC_DIGIT;
          end else begin
            group.bytes[0] = PCT_CHAR;
            if (start_esc) begin
              state_next.escape_stage = ESC_PCT;
              group.count             = 2'd1;
            end else begin
              group.bytes[1] = in_char;
              group.count    = 2'd2;
            end
          end
        end
        ESC_DIGIT: begin
          if (hx_held.valid && hx_c.valid) begin
            group.bytes[0] = {hx_held.value, hx_c.value};
            group.count    = 2'd1;
          end else begin
            group.bytes[0] = PCT_CHAR;
            group.bytes[1] = state.held_char;
            if (start_esc) begin
              state_next.escape_stage = ESC_PCT;
              group.count             = 2'd2;
            end else begin
              group.bytes[2] = in_char;
              group.count    = 2'd3;
            end
          end
        end
        default: begin
          if (start_esc) begin
            state_next.escape_stage = ESC_PCT;
          end else begin
            group.bytes[0] = in_char;
            group.count    = 2'd1;
          end
        end
      endcase
    end

    if (in_last) begin
      state_next = '0;
    end
  end

endmodule

### sv/dup_out_group.sv
// ----------------------------------------------------------------------------
// dup_out_group
// Result register holding one group of decoded bytes, sent out one per cycle while the sink is ready.
// ----------------------------------------------------------------------------
module dup_out_group (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  dup_pkg::dup_group_t group,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               run_last
);
  import dup_pkg::*;

  logic [1:0]                  count;
  logic [1:0]                  idx;
  logic [MAX_RESULTS-1:0][7:0] bytes;
  logic                        drain;

  assign out_valid = (count != 2'd0);
  assign run_last  = (idx == count - 2'd1);
  assign out_byte  = bytes[idx];
  assign drain     = out_valid && out_ready;
  assign free      = !out_valid || (drain && run_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      idx   <= 2'd0;
    end else if (load) begin
      count <= group.count;
      idx   <= 2'd0;
    end else if (drain) begin
      if (run_last) begin
        count <= 2'd0;
        idx   <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= group.bytes;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> idx < count)
    else $error("result index beyond group size");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("group loaded over undelivered results");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
    else $error("stalled result changed");

endmodule

### sv/data_url_payload_decoder.sv
// ----------------------------------------------------------------------------
// data_url_payload_decoder
// Base64 or percent decoder for data URL payload characters.
// ----------------------------------------------------------------------------
// One character is taken per request and a new one can be accepted every
// cycle while the result register is free. A character enters an input
// register, is decoded there and its bytes land in a result register that
// sends one byte per cycle while the sink is ready, so the rate is one
// character per cycle while each gives at most one byte; a broken percent
// escape gives up to three bytes and holds the input while they drain. The
// mode register may be written only while no character is in flight.
module data_url_payload_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);
  import dup_pkg::*;

  logic       decode_mode;
  logic       ireg_valid;
  logic [7:0] ireg_char;
  logic       ireg_last;
  dup_state_t state;
  dup_state_t state_next;
  dup_group_t group;
  logic       free;
  logic       move;

  assign cfg_ready = 1'b1;
  assign move      = ireg_valid && free;
  assign in_ready  = !ireg_valid || free;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= MODE_PERCENT;
    end else if (cfg_valid && cfg_ready) begin
      decode_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (in_ready) begin
      ireg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ireg_char <= in_char;
      ireg_last <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (move) begin
      state <= state_next;
    end
  end

  dup_decode u_decode (
    .mode       (decode_mode),
    .in_char    (ireg_char),
    .in_last    (ireg_last),
    .state      (state),
    .state_next (state_next),
    .group      (group)
  );

  dup_out_group u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (move),
    .group     (group),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_last  (run_last)
  );

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    move && ireg_last |=> state == '0)
    else $error("state not cleared after last character");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    ireg_valid && !move |=> ireg_valid && $stable(ireg_char) && $stable(ireg_last))
    else $error("pending character lost");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    state.bit_count <= 4'd10)
    else $error("bit count out of range");

endmodule

### test/payload_decode_checker.sv
// ----------------------------------------------------------------------------
// payload_decode_checker
// Watches the character, mode and byte channels of the payload decoder,
// predicts the decoded bytes of every accepted character and compares each
// delivered byte and its end flag against the oldest prediction.
// ----------------------------------------------------------------------------
module payload_decode_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       run_last,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_data,
  output int         pending,
  output int         errors
);
  import dup_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } decoded_t;

  decoded_t    byte_q[$];
  logic [7:0]  burst[$];
  decoded_t    want;

  logic        mode;
  logic [11:0] bit_buf;
  logic [3:0]  bit_cnt;
  logic [1:0]  esc;
  logic [7:0]  held;

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return int'(c) - int'("0");
    end
    if (c >= "a" && c <= "f") begin
      return int'(c) - int'("a") + 10;
    end
    if (c >= "A" && c <= "F") begin
      return int'(c) - int'("A") + 10;
    end
    return -1;
  endfunction

  function automatic int sextet_of(input logic [7:0] c);
    if (c >= "A" && c <= "Z") begin
      return int'(c) - int'("A");
    end
    if (c >= "a" && c <= "z") begin
      return int'(c) - int'("a") + 26;
    end
    if (c >= "0" && c <= "9") begin
      return int'(c) - int'("0") + 52;
    end
    if (c == "+") begin
      return 62;
    end
    if (c == "/") begin
      return 63;
    end
    return -1;
  endfunction

  task automatic add_burst(input logic [7:0] c);
    burst = {burst, c};
  endtask

  task automatic emit_plain(input logic [7:0] c, input logic last);
    if (c == PCT_CHAR) begin
      if (last) begin
        add_burst(PCT_CHAR);
      end else begin
        esc = ESC_PCT;
      end
    end else begin
      add_burst(c);
    end
  endtask

  task automatic decode_char(input logic [7:0] c, input logic last);
    int          v;
    int          hi;
    int          lo;
    logic [1:0]  stage;
    logic [11:0] shifted;
    decoded_t    item;
    burst.delete();
    if (mode == MODE_BASE64) begin
      v = sextet_of(c);
      if (v >= 0) begin
        bit_buf = {bit_buf[5:0], v[5:0]};
        bit_cnt = bit_cnt + 4'd6;
        if (bit_cnt >= 4'd8) begin
          bit_cnt = bit_cnt - 4'd8;
          shifted = bit_buf >> bit_cnt;
          add_burst(shifted[7:0]);
        end
      end
    end else begin
      stage = esc;
      esc = ESC_NONE;
      if (stage == ESC_PCT) begin
        if (nibble_of(c) >= 0 && !last) begin
          held = c;
          esc = ESC_DIGIT;
        end else begin
          add_burst(PCT_CHAR);
          emit_plain(c, last);
        end
      end else if (stage == ESC_DIGIT) begin
        hi = nibble_of(held);
        lo = nibble_of(c);
        if (hi >= 0 && lo >= 0) begin
          add_burst({hi[3:0], lo[3:0]});
        end else begin
          add_burst(PCT_CHAR);
          add_burst(held);
          emit_plain(c, last);
        end
      end else begin
        emit_plain(c, last);
      end
    end
    foreach (burst[i]) begin
      item.data = burst[i];
      item.fin  = (i == burst.size() - 1);
      byte_q = {byte_q, item};
    end
    if (last) begin
      bit_buf = '0;
      bit_cnt = '0;
      esc = ESC_NONE;
      held = '0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      byte_q.delete();
      mode = MODE_PERCENT;
      bit_buf = '0;
      bit_cnt = '0;
      esc = ESC_NONE;
      held = '0;
      errors <= 0;
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (byte_q.size() == 0) begin
          if (errors < 10) begin
            $display("unexpected byte %02h last %0b with nothing predicted",
                     out_byte, run_last);
          end
          errors <= errors + 1;
        end else begin
          want = byte_q.pop_front();
          if (out_byte !== want.data || run_last !== want.fin) begin
            if (errors < 10) begin
              $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                       want.data, want.fin, out_byte, run_last);
            end
            errors <= errors + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        mode = cfg_data;
      end
      if (in_valid && in_ready) begin
        decode_char(in_char, in_last);
      end
      pending <= byte_q.size();
    end
  end

endmodule

### test/data_url_payload_decoder_tb.sv
// ----------------------------------------------------------------------------
// data_url_payload_decoder_tb
// Drives payload characters in percent and base64 mode into the decoder,
// starting with hand-picked escapes and edge characters and moving on to
// random payloads, with random stalls on both sides and one long stall of
// the byte sink. A separate checker predicts and compares every byte.
// ----------------------------------------------------------------------------
module data_url_payload_decoder_tb;
  import dup_pkg::*;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;

  int         pending;
  int         errors;

  bit         no_idle = 1'b0;
  bit         hold_req = 1'b0;
  logic [7:0] seq[$];
  string      hex_chars = "0123456789abcdefABCDEF";

  data_url_payload_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_char   (in_char),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  payload_decode_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_char   (in_char),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .errors    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] b64_char(input int v);
    if (v < 26) begin
      return 8'("A" + v);
    end
    if (v < 52) begin
      return 8'("a" + v - 26);
    end
    if (v < 62) begin
      return 8'("0" + v - 52);
    end
    return (v == 62) ? 8'h2B : 8'h2F;
  endfunction

  function automatic logic [7:0] hex_char();
    return hex_chars[$urandom_range(0, 21)];
  endfunction

  // Byte sink: random stalls, except for one long hold-off on request and a phase with no stalls.
  initial begin
    int gap;
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_req = 1'b0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        gap = idle_len();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic l);
    int gap;
    gap = (no_idle || hold_req) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char <= c;
    in_last <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_seq(input logic end_last);
    int n;
    n = seq.size();
    for (int i = 0; i < n; i++) begin
      send_char(seq[i], end_last && (i == n - 1));
    end
    seq.delete();
  endtask

  task automatic add_char(input logic [7:0] c);
    seq = {seq, c};
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_char(s[i]);
    end
  endtask

  task automatic cfg_write(input logic m);
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic make_piece(input logic m);
    int r;
    r = $urandom_range(0, 99);
    if (m == MODE_BASE64) begin
      if (r < 75) begin
        add_char(b64_char($urandom_range(0, 63)));
      end else if (r < 90) begin
        case ($urandom_range(0, 4))
          0: add_char("=");
          1: add_char(8'h0D);
          2: add_char(8'h0A);
          3: add_char(" ");
          default: add_char(8'h09);
        endcase
      end else begin
        add_char(8'($urandom_range(0, 255)));
      end
    end else begin
      if (r < 45) begin
        add_char(8'($urandom_range(0, 255)));
      end else if (r < 80) begin
        add_char(PCT_CHAR);
        add_char(hex_char());
        add_char(hex_char());
      end else if (r < 95) begin
        add_char(PCT_CHAR);
        add_char(hex_char());
        add_char(8'($urandom_range(0, 255)));
      end else begin
        add_char(PCT_CHAR);
        add_char(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int   sent;
    int   waited;
    logic m;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cfg_write(MODE_PERCENT);
    push_text("%41%6f");
    add_char(8'hFF);
    add_char(8'h00);
    push_text("%G%");
    send_seq(1'b1);
    push_text("%4%");
    send_seq(1'b1);
    push_text("%A");
    send_seq(1'b1);

    cfg_write(MODE_BASE64);
    push_text("TW");
    add_char(8'h0A);
    add_char(8'hFF);
    push_text("F+/=");
    send_seq(1'b1);

    for (int p = 0; p < 10; p++) begin
      m = (p < 6) ? p[0] : 1'($urandom_range(0, 1));
      if (p == 2) begin
        m = MODE_PERCENT;
      end
      cfg_write(m);
      no_idle = (p == 5);
      if (p == 2) begin
        hold_req = 1'b1;
      end
      sent = 0;
      while (sent < 24) begin
        make_piece(m);
        sent += seq.size();
        send_seq($urandom_range(0, 9) == 0);
      end
      no_idle = 1'b0;
    end

    in_valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
sv/dup_pkg.sv
sv/dup_decode.sv
sv/dup_out_group.sv
sv/data_url_payload_decoder.sv
test/payload_decode_checker.sv
test/data_url_payload_decoder_tb.sv
